/* hw/rtl/length_prefixed_unit_deframer_assert.svh */
// ----------------------------------------------------------------------------
// Length-prefixed unit deframer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_UNIT_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_UNIT_DEFRAMER_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define LPUD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lpud assertion failed");

// Check that a condition holds in the cycle after a trigger.
`define LPUD_ASSERT_NEXT(name, trig, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error("lpud assertion failed");

`endif

/* hw/rtl/lpud_pkg.sv */
// ----------------------------------------------------------------------------
// Length-prefixed unit deframer package
// Word types, field widths, register indexes and status codes.
// ----------------------------------------------------------------------------
package lpud_pkg;

  localparam int OFFSET_BITS     = 24;
  localparam int UNIT_COUNT_BITS = 16;
  localparam int ACC_BITS        = 32;

  // Configuration register indexes
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAMING_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PREFIX_SIZE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNIT_LIMIT   = 2'd2;

  // Framing modes
  localparam logic [1:0] MODE_OPAQUE   = 2'd0;
  localparam logic [1:0] MODE_PREFIXED = 2'd1;

  localparam logic [1:0]  MODE_RESET   = MODE_PREFIXED;
  localparam logic [2:0]  PREFIX_RESET = 3'd4;
  localparam logic [15:0] LIMIT_RESET  = 16'd1024;

  typedef enum logic {
    KIND_UNIT   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_FRAMED      = 3'd0,
    ST_UNSUPPORTED = 3'd1,
    ST_TRUNCATED   = 3'd2,
    ST_ZERO_LENGTH = 3'd3,
    ST_LIMIT       = 3'd4,
    ST_INVALID     = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    kind_e                      kind;
    logic [UNIT_COUNT_BITS-1:0] unit_number;
    logic [OFFSET_BITS-1:0]     prefix_offset;
    logic [2:0]                 prefix_bytes;
    logic [OFFSET_BITS-1:0]     payload_offset;
    logic [OFFSET_BITS-1:0]     payload_length;
    status_e                    status;
    logic [OFFSET_BITS-1:0]     framed_bytes;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  framing_mode;
    logic [2:0]  prefix_size;
    logic [15:0] unit_limit;
  } cfg_t;

endpackage

/* hw/rtl/lpud_regs.sv */
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Holds framing mode, prefix size and unit limit written over the config port.
// ----------------------------------------------------------------------------
module lpud_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [lpud_pkg::CFG_IDX_BITS-1:0] wr_index_i,
  input  logic [lpud_pkg::CFG_DATA_BITS-1:0] wr_data_i,
  output lpud_pkg::cfg_t                    cfg_o
);
  import lpud_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        REG_FRAMING_MODE: cfg_d.framing_mode = wr_data_i[1:0];
        REG_PREFIX_SIZE:  cfg_d.prefix_size  = wr_data_i[2:0];
        REG_UNIT_LIMIT:   cfg_d.unit_limit   = wr_data_i[15:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.framing_mode <= MODE_RESET;
      cfg_q.prefix_size  <= PREFIX_RESET;
      cfg_q.unit_limit   <= LIMIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/lpud_core.sv */
// ----------------------------------------------------------------------------
// Deframer byte engine
// Updates the per-sample parse state for one byte and forms up to two words.
// ----------------------------------------------------------------------------
module lpud_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  lpud_pkg::in_item_t  item_i,
  input  lpud_pkg::cfg_t      cfg_i,
  output logic [1:0]          res_cnt_o,
  output lpud_pkg::out_item_t res_a_o,
  output lpud_pkg::out_item_t res_b_o
);
  import lpud_pkg::*;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  logic [OFFSET_BITS-1:0]     pos_q, pos_d;
  logic [ACC_BITS-1:0]        acc_q, acc_d;
  logic [2:0]                 pleft_q, pleft_d;
  logic [ACC_BITS-1:0]        pay_q, pay_d;
  logic [UNIT_COUNT_BITS-1:0] ucnt_q, ucnt_d;
  logic [OFFSET_BITS-1:0]     poff_q, poff_d;
  status_e                    err_q, err_d;
  logic                       open_q, open_d;
  cfg_t                       lat_q, lat_d;

  always_comb begin
    cfg_t                   cur;
    status_e                cfg_err;
    status_e                err;
    logic                   go;
    logic [2:0]             pleft;
    logic [ACC_BITS-1:0]    acc;
    logic                   have_desc;
    logic                   have_opaque;
    logic [OFFSET_BITS-1:0] total;
    out_item_t              unit_w;
    out_item_t              stat_w;

    pos_d       = pos_q;
    acc_d       = acc_q;
    pleft_d     = pleft_q;
    pay_d       = pay_q;
    ucnt_d      = ucnt_q;
    poff_d      = poff_q;
    err_d       = err_q;
    open_d      = open_q;
    lat_d       = lat_q;
    go          = 1'b0;
    pleft       = pleft_q;
    acc         = acc_q;
    have_desc   = 1'b0;
    have_opaque = 1'b0;
    unit_w      = '0;
    stat_w      = '0;
    res_cnt_o   = 2'd0;
    res_a_o     = '0;
    res_b_o     = '0;

    // First byte of a sample takes a fresh copy of the configuration
    cur = open_q ? lat_q : cfg_i;
    cfg_err = ST_FRAMED;
    if (cur.framing_mode != MODE_OPAQUE && cur.framing_mode != MODE_PREFIXED) begin
      cfg_err = ST_UNSUPPORTED;
    end else if (cur.framing_mode == MODE_PREFIXED) begin
      if (!(cur.prefix_size inside {3'd1, 3'd2, 3'd4})) begin
        cfg_err = ST_UNSUPPORTED;
      end else if (cur.unit_limit == '0) begin
        cfg_err = ST_INVALID;
      end
    end
    err = open_q ? err_q : cfg_err;
    total = pos_q + OFFSET_BITS'(1);

    if (step_i) begin
      open_d = 1'b1;
      lat_d  = cur;
      if (err == ST_FRAMED && pos_q == POS_MAX) begin
        err = ST_LIMIT;
      end

      if (err == ST_FRAMED && cur.framing_mode == MODE_PREFIXED) begin
        if (pay_q != '0) begin
          pay_d = pay_q - ACC_BITS'(1);
          if (pay_q == ACC_BITS'(1)) begin
            have_desc             = 1'b1;
            unit_w.kind           = KIND_UNIT;
            unit_w.unit_number    = ucnt_q;
            unit_w.prefix_offset  = poff_q;
            unit_w.prefix_bytes   = cur.prefix_size;
            unit_w.payload_offset = poff_q + OFFSET_BITS'(cur.prefix_size);
            unit_w.payload_length = OFFSET_BITS'(acc_q);
            ucnt_d                = ucnt_q + UNIT_COUNT_BITS'(1);
          end
        end else begin
          go = 1'b1;
          if (pleft_q == 3'd0) begin
            if (32'(ucnt_q) >= 32'(cur.unit_limit) || ucnt_q == '1) begin
              err = ST_LIMIT;
              go  = 1'b0;
            end else begin
              poff_d = pos_q;
              pleft  = cur.prefix_size;
              acc    = '0;
            end
          end
          if (go) begin
            acc   = {acc[ACC_BITS-9:0], item_i.data_byte};
            pleft = pleft - 3'd1;
            if (pleft == 3'd0) begin
              if (acc == '0) begin
                err = ST_ZERO_LENGTH;
              end else begin
                pay_d = acc;
              end
            end
            pleft_d = pleft;
            acc_d   = acc;
          end
        end
      end

      if (item_i.last_byte) begin
        if (err == ST_FRAMED && cur.framing_mode == MODE_PREFIXED &&
            (pleft_d != 3'd0 || pay_d != '0)) begin
          err = ST_TRUNCATED;
        end
        if (err == ST_FRAMED && cur.framing_mode == MODE_OPAQUE) begin
          have_opaque           = 1'b1;
          unit_w                = '0;
          unit_w.kind           = KIND_UNIT;
          unit_w.payload_length = total;
        end
        stat_w.kind         = KIND_STATUS;
        stat_w.status       = err;
        stat_w.framed_bytes = (err == ST_FRAMED) ? total : '0;
        stat_w.last         = 1'b1;

        // Close the sample
        pos_d   = '0;
        acc_d   = '0;
        pleft_d = 3'd0;
        pay_d   = '0;
        ucnt_d  = '0;
        poff_d  = '0;
        err_d   = ST_FRAMED;
        open_d  = 1'b0;

        if (have_desc || have_opaque) begin
          res_cnt_o = 2'd2;
          res_a_o   = unit_w;
          res_b_o   = stat_w;
        end else begin
          res_cnt_o = 2'd1;
          res_a_o   = stat_w;
        end
      end else begin
        err_d = err;
        if (pos_q != POS_MAX) begin
          pos_d = pos_q + OFFSET_BITS'(1);
        end
        if (have_desc) begin
          res_cnt_o = 2'd1;
          res_a_o   = unit_w;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q              <= '0;
      acc_q              <= '0;
      pleft_q            <= 3'd0;
      pay_q              <= '0;
      ucnt_q             <= '0;
      poff_q             <= '0;
      err_q              <= ST_FRAMED;
      open_q             <= 1'b0;
      lat_q.framing_mode <= MODE_RESET;
      lat_q.prefix_size  <= PREFIX_RESET;
      lat_q.unit_limit   <= LIMIT_RESET;
    end else begin
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      pleft_q <= pleft_d;
      pay_q   <= pay_d;
      ucnt_q  <= ucnt_d;
      poff_q  <= poff_d;
      err_q   <= err_d;
      open_q  <= open_d;
      lat_q   <= lat_d;
    end
  end

endmodule

/* hw/rtl/lpud_fifo.sv */
// ----------------------------------------------------------------------------
// Deframer result queue
// Takes up to two words per cycle from the byte engine, hands out one a cycle unless stalled.
// ----------------------------------------------------------------------------
module lpud_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_cnt_i,
  input  lpud_pkg::out_item_t push_a_i,
  input  lpud_pkg::out_item_t push_b_i,
  output logic                room2_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpud_pkg::out_item_t out_item_o
);
  import lpud_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  out_item_t       mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            pop;
  logic [AW-1:0]   wr_next;

  assign pop         = out_valid_o && !out_stall_i;
  assign wr_next     = wr_ptr_q + AW'(1);
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign room2_o     = (count_q <= CW'(DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + AW'(push_cnt_i);
    rd_ptr_d = pop ? rd_ptr_q + AW'(1) : rd_ptr_q;
    count_d  = count_q + CW'(push_cnt_i) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_a_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_next] <= push_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* hw/rtl/length_prefixed_unit_deframer.sv */
// ----------------------------------------------------------------------------
// Length-prefixed unit deframer
// Splits a byte stream of samples into unit descriptors and a closing status.
// ----------------------------------------------------------------------------
// Each accepted byte is registered, then its words pass through the byte engine into the queue.
// Throughput: one byte per cycle while the queue has room for two words; the final byte
// of a sample may add one word, which the result queue (RESULT_DEPTH words, a power of two
// >= 4) absorbs; a run of one-byte opaque samples (two words each) stalls the input.
// Reset: asynchronous, active low; clears parse state and queue, loads register
// defaults (prefixed mode, 4 byte prefix, 1024 units).
module length_prefixed_unit_deframer #(
  parameter int RESULT_DEPTH = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  lpud_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output lpud_pkg::out_item_t                out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lpud_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [lpud_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import lpud_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q, in_vld_d;
  logic      room2;
  logic      step;
  logic      accept;
  logic [1:0] res_cnt;
  out_item_t res_a, res_b;

  assign cfg_ready_o = 1'b1;

  lpud_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Hold the input word until the queue has room for both possible results
  assign step       = in_vld_q && room2;
  assign in_stall_o = in_vld_q && !room2;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
  end

  lpud_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .res_cnt_o (res_cnt),
    .res_a_o   (res_a),
    .res_b_o   (res_b)
  );

  lpud_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (res_cnt),
    .push_a_i    (res_a),
    .push_b_i    (res_b),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* hw/rtl/lpud_checker.sv */
// ----------------------------------------------------------------------------
// Length-prefixed unit deframer port checker
// Watches the top-level ports for handshake and result word consistency.
// ----------------------------------------------------------------------------
`include "length_prefixed_unit_deframer_assert.svh"

module lpud_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lpud_pkg::out_item_t out_item_o
);
  import lpud_pkg::*;

  `LPUD_ASSERT_NEXT(a_out_valid_held, out_valid_o && out_stall_i, out_valid_o)
  `LPUD_ASSERT_NEXT(a_out_word_held, out_valid_o && out_stall_i, $stable(out_item_o))
  // Input backpressure only comes from a queue that holds words
  `LPUD_ASSERT(a_stall_has_words, in_stall_o |-> out_valid_o)
  // Payload follows its prefix in every descriptor, and no descriptor carries last
  `LPUD_ASSERT(a_desc_layout,
    (out_valid_o && out_item_o.kind == KIND_UNIT) |->
      (!out_item_o.last && out_item_o.payload_offset ==
       out_item_o.prefix_offset + OFFSET_BITS'(out_item_o.prefix_bytes)))

endmodule

bind length_prefixed_unit_deframer lpud_checker u_lpud_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
